@@ rtl/core/bcw_pkg.sv @@
// Shared types and constants for the barycentric weight pipeline.
`default_nettype none
package bcw_pkg;

  // Fixed field widths of the request and response
  localparam int COORD_W  = 16;
  localparam int WEIGHT_W = 32;
  // One extra quotient bit catches a weight of exactly minus one full scale
  localparam int QUOT_W   = WEIGHT_W + 1;

  localparam int COORD_BITS_DEF       = 16;
  localparam int WEIGHT_FRAC_BITS_DEF = 16;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
    logic signed [COORD_W-1:0] p_x;
    logic signed [COORD_W-1:0] p_y;
    logic signed [COORD_W-1:0] p_z;
  } req_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] weight_a;
    logic signed [WEIGHT_W-1:0] weight_b;
    logic signed [WEIGHT_W-1:0] weight_c;
    logic                       degenerate;
  } rsp_t;

endpackage
`default_nettype wire

@@ rtl/core/bcw_divider.sv @@
// Pipelined restoring divider: signed numerator over positive denominator, saturated weight.
`default_nettype none
module bcw_divider
  import bcw_pkg::*;
#(
  parameter int NUM_W     = 72,
  parameter int FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [NUM_W-1:0]    num,
  input  wire logic        [NUM_W-1:0]    den,
  output logic             [WEIGHT_W-1:0] weight
);

  localparam int DVD_W = NUM_W + FRAC_BITS;

  logic [NUM_W-1:0]  rem    [QUOT_W+1];
  logic [QUOT_W-1:0] lo     [QUOT_W+1];
  logic [QUOT_W-1:0] quo    [QUOT_W+1];
  logic [NUM_W-1:0]  den_s  [QUOT_W+1];
  logic              neg_s  [QUOT_W+1];
  logic              ovf_s  [QUOT_W+1];

  logic              neg;
  logic [NUM_W-1:0]  mag;
  logic [DVD_W-1:0]  dvd;
  logic [NUM_W-1:0]  hi;

  // Split magnitude into the part that must stay below den and the bits to shift in
  always_comb begin
    neg = num[NUM_W-1];
    mag = neg ? NUM_W'(-num) : NUM_W'(num);
    dvd = {mag, {FRAC_BITS{1'b0}}};
    hi  = NUM_W'(dvd[DVD_W-1:QUOT_W]);
  end

  // Register operands and the overflow verdict
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= hi;
      lo[0]    <= dvd[QUOT_W-1:0];
      quo[0]   <= '0;
      den_s[0] <= den;
      neg_s[0] <= neg;
      ovf_s[0] <= (hi >= den);
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < QUOT_W; k++) begin : g_step
    logic [NUM_W-1:0] rs;
    logic [NUM_W:0]   diff;
    logic             ge;

    always_comb begin
      rs   = {rem[k][NUM_W-2:0], lo[k][QUOT_W-1]};
      diff = {1'b0, rs} - {1'b0, den_s[k]};
      ge   = ~diff[NUM_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge ? diff[NUM_W-1:0] : rs;
        lo[k+1]    <= {lo[k][QUOT_W-2:0], 1'b0};
        quo[k+1]   <= {quo[k][QUOT_W-2:0], ge};
        den_s[k+1] <= den_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  // Apply sign and saturate
  always_comb begin
    if (neg_s[QUOT_W]) begin
      if (ovf_s[QUOT_W] || (quo[QUOT_W] > QUOT_W'(WEIGHT_MIN))) begin
        weight = WEIGHT_MIN;
      end else begin
        weight = WEIGHT_W'(-quo[QUOT_W]);
      end
    end else begin
      if (ovf_s[QUOT_W] || (quo[QUOT_W] > QUOT_W'(WEIGHT_MAX))) begin
        weight = WEIGHT_MAX;
      end else begin
        weight = WEIGHT_W'(quo[QUOT_W]);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/barycentric_weights_3d.sv @@
// Top level of the barycentric weight pipeline.
// Usage:
//   Request channel (req_valid/req_ready/req) takes vertices A, B, C and query
//   point P, signed fixed point, low COORD_BITS bits of each field used.
//   Response channel (rsp_valid/rsp_ready/rsp) returns weights for A, B, C with
//   WEIGHT_FRAC_BITS fraction bits, truncated toward zero and saturated to 32
//   bits, plus a degenerate flag (zero-area triangle, weights then zero).
// Throughput: one request per cycle unless stalled; each stage holds one.
// Stages from request accept to response valid: six arithmetic
//   stages (differences, cross products, dot products split into partial
//   products), one divider setup stage, 33 stages of the restoring divider
//   (one quotient bit each) and the response register.
// Stall: the whole pipeline advances together; while a response waits unread
//   req_ready drops and every stage holds. Nothing is lost or repeated.
// Reset: rst is synchronous and clears every valid bit; data registers are
//   not reset. The block takes requests in the first cycle after reset.
`default_nettype none
module barycentric_weights_3d
  import bcw_pkg::*;
#(
  parameter int COORD_BITS       = COORD_BITS_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int C_W  = COORD_BITS;
  localparam int D_W  = C_W + 1;          // coordinate difference
  localparam int XP_W = 2 * D_W;          // one cross product term
  localparam int X_W  = 2 * C_W + 3;      // cross product component
  localparam int L_W  = (X_W + 1) / 2;    // low half for split multiply
  localparam int H_W  = X_W - L_W;
  localparam int PP_W = 2 * (L_W + 1);    // partial product
  localparam int PX_W = 2 * X_W;          // full dot term
  localparam int S_W  = PX_W + 2;         // dot product sum
  localparam int NSTG = 6 + QUOT_W + 1;   // arithmetic + divider setup + steps

  localparam int CU [4] = '{0, 3, 2, 0};  // ba, pb, pa, ba
  localparam int CV [4] = '{1, 4, 1, 2};  // ca, pc, ca, pa

  logic                 en;
  logic [NSTG-1:0]      vld;
  logic [QUOT_W:0]      degen;

  logic signed [C_W-1:0]  crd [4][3];
  logic signed [D_W-1:0]  dv  [5][3];
  logic signed [XP_W-1:0] xp  [4][3][2];
  logic signed [X_W-1:0]  cr  [4][3];
  logic signed [PP_W-1:0] pp  [12][4];
  logic signed [PX_W-1:0] prod [12];
  logic signed [S_W-1:0]  dsum [4];
  logic [WEIGHT_W-1:0]    wgt  [3];

  // Advance everything when the response slot is free or being read
  assign en        = ~rsp_valid | rsp_ready;
  assign req_ready = en & ~rst;

  // Take the low coordinate bits and sign-extend
  always_comb begin
    crd[0][0] = $signed(C_W'($unsigned(req.a_x)));
    crd[0][1] = $signed(C_W'($unsigned(req.a_y)));
    crd[0][2] = $signed(C_W'($unsigned(req.a_z)));
    crd[1][0] = $signed(C_W'($unsigned(req.b_x)));
    crd[1][1] = $signed(C_W'($unsigned(req.b_y)));
    crd[1][2] = $signed(C_W'($unsigned(req.b_z)));
    crd[2][0] = $signed(C_W'($unsigned(req.c_x)));
    crd[2][1] = $signed(C_W'($unsigned(req.c_y)));
    crd[2][2] = $signed(C_W'($unsigned(req.c_z)));
    crd[3][0] = $signed(C_W'($unsigned(req.p_x)));
    crd[3][1] = $signed(C_W'($unsigned(req.p_y)));
    crd[3][2] = $signed(C_W'($unsigned(req.p_z)));
  end

  // Stage 1: edge and offset vectors
  for (genvar j = 0; j < 3; j++) begin : g_diff
    always_ff @(posedge clk) begin
      if (en) begin
        dv[0][j] <= D_W'(crd[1][j]) - D_W'(crd[0][j]);
        dv[1][j] <= D_W'(crd[2][j]) - D_W'(crd[0][j]);
        dv[2][j] <= D_W'(crd[3][j]) - D_W'(crd[0][j]);
        dv[3][j] <= D_W'(crd[3][j]) - D_W'(crd[1][j]);
        dv[4][j] <= D_W'(crd[3][j]) - D_W'(crd[2][j]);
      end
    end
  end

  // Stages 2 and 3: cross product terms, then their differences
  for (genvar g = 0; g < 4; g++) begin : g_cross
    for (genvar j = 0; j < 3; j++) begin : g_comp
      always_ff @(posedge clk) begin
        if (en) begin
          xp[g][j][0] <= XP_W'(dv[CU[g]][(j+1)%3]) * XP_W'(dv[CV[g]][(j+2)%3]);
          xp[g][j][1] <= XP_W'(dv[CU[g]][(j+2)%3]) * XP_W'(dv[CV[g]][(j+1)%3]);
          cr[g][j]    <= X_W'(xp[g][j][0]) - X_W'(xp[g][j][1]);
        end
      end
    end
  end

  // Stages 4 and 5: dot terms as four partial products, then recombine
  for (genvar t = 0; t < 12; t++) begin : g_term
    logic signed [X_W-1:0] opa, opb;
    logic signed [H_W-1:0] ah, bh;
    logic signed [L_W:0]   al, bl;

    always_comb begin
      opa = cr[0][t%3];
      opb = cr[t/3][t%3];
      ah  = $signed(opa[X_W-1:L_W]);
      bh  = $signed(opb[X_W-1:L_W]);
      al  = $signed({1'b0, opa[L_W-1:0]});
      bl  = $signed({1'b0, opb[L_W-1:0]});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pp[t][0] <= PP_W'(ah) * PP_W'(bh);
        pp[t][1] <= PP_W'(ah) * PP_W'(bl);
        pp[t][2] <= PP_W'(al) * PP_W'(bh);
        pp[t][3] <= PP_W'(al) * PP_W'(bl);
        prod[t]  <= (PX_W'(pp[t][0]) <<< (2 * L_W))
                  + ((PX_W'(pp[t][1]) + PX_W'(pp[t][2])) <<< L_W)
                  + PX_W'(pp[t][3]);
      end
    end
  end

  // Stage 6: sum three terms per dot product (n.n, then the three numerators)
  for (genvar v = 0; v < 4; v++) begin : g_dot
    always_ff @(posedge clk) begin
      if (en) begin
        dsum[v] <= S_W'(prod[3*v]) + S_W'(prod[3*v+1]) + S_W'(prod[3*v+2]);
      end
    end
  end

  // Divide each numerator by n.n
  for (genvar w = 0; w < 3; w++) begin : g_div
    bcw_divider #(
      .NUM_W    (S_W),
      .FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_div (
      .clk   (clk),
      .en    (en),
      .num   (dsum[w+1]),
      .den   ($unsigned(dsum[0])),
      .weight(wgt[w])
    );
  end

  // Carry the degenerate flag alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      degen <= {degen[QUOT_W-1:0], (dsum[0] == '0)};
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NSTG-2:0], req_valid};
      rsp_valid <= vld[NSTG-1];
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.degenerate <= degen[QUOT_W];
      rsp.weight_a   <= degen[QUOT_W] ? '0 : $signed(wgt[0]);
      rsp.weight_b   <= degen[QUOT_W] ? '0 : $signed(wgt[1]);
      rsp.weight_c   <= degen[QUOT_W] ? '0 : $signed(wgt[2]);
    end
  end

`ifndef SYNTHESIS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> vld[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> ($stable(vld) && rsp_valid))
    else $error("pipeline moved during a stall");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.degenerate) |->
      (rsp.weight_a == '0 && rsp.weight_b == '0 && rsp.weight_c == '0))
    else $error("degenerate response with nonzero weights");
`endif

endmodule
`default_nettype wire
